### rtl/iia_pkg.sv
// Shared constants and types for the interval ID allocator.
// No dependencies; imported by the interfaces and the top level.
`default_nettype none

package iia_pkg;

	localparam int ID_BITS_DEF       = 32;
	localparam int MAX_INTERVALS_DEF = 64;
	localparam int ID_W              = 32;

	typedef logic [2:0] status_t;

	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_EXHAUSTED = 3'd1;
	localparam status_t ST_INVALID   = 3'd2;
	localparam status_t ST_FREED     = 3'd3;
	localparam status_t ST_FULL      = 3'd4;

endpackage

`default_nettype wire

### rtl/iia_if.sv
// Request and response channel interfaces of the interval ID allocator.
// Depends on iia_pkg.
`default_nettype none

interface iia_req_if import iia_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            req_type;
	logic [ID_W-1:0] free_id;

	modport source (output valid, req_type, free_id, input ready);
	modport sink   (input valid, req_type, free_id, output ready);
endinterface

interface iia_rsp_if import iia_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [ID_W-1:0] granted_id;
	status_t         status;
	logic [ID_W-1:0] high_water;

	modport source (output valid, granted_id, status, high_water, input ready);
	modport sink   (input valid, granted_id, status, high_water, output ready);
endinterface

`default_nettype wire

### rtl/iia_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module iia_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/interval_id_allocator.sv
// Interval ID allocator: top level with request/response channels.
// Depends on iia_pkg, iia_req_if, iia_rsp_if and iia_ram.
//
// Hands out the lowest free positive ID and takes IDs back, keeping a
// high-water mark and a sorted table of free intervals in one RAM. One
// request is worked at a time. An allocate from an empty table is served
// from the high-water mark; one that shrinks the first interval rewrites
// it, and one that empties it moves every later entry down. A free of an
// invalid ID needs no table access. Any other free scans the table, which
// stops at the first entry that ends at or above the ID. An insert or a
// removal moves each entry with a read and then a write, as the RAM has a
// single read and a single write port.
// The result register lets the next request start while a word waits.
// No clearing pass follows reset.
`default_nettype none

module interval_id_allocator import iia_pkg::*; #(
	parameter int ID_BITS       = ID_BITS_DEF,
	parameter int MAX_INTERVALS = MAX_INTERVALS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	iia_req_if.sink  req,
	iia_rsp_if.source rsp
);

	localparam int CW  = (ID_BITS > ID_W) ? ID_BITS : ID_W;
	localparam int CW1 = CW + 1;
	localparam int AW  = $clog2(MAX_INTERVALS);
	localparam int NW  = $clog2(MAX_INTERVALS + 1);
	localparam int NW1 = NW + 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ARD  = 3'd1;
	localparam logic [2:0] S_SRD  = 3'd2;
	localparam logic [2:0] S_DEC  = 3'd3;
	localparam logic [2:0] S_SH   = 3'd4;
	localparam logic [2:0] S_SHW  = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	typedef struct packed {
		logic [ID_BITS-1:0] b;
		logic [ID_BITS-1:0] e;
	} ivl_t;

	logic [2:0]         state_q, state_d;
	logic [NW-1:0]      cnt_q, cnt_d, r_q, r_d, i_q, i_d;
	logic [1:0]         k_q, k_d;
	logic               up_q, up_d;
	logic [ID_BITS-1:0] mark_q, mark_d, gid_q, gid_d;
	logic [CW-1:0]      id_q, id_d;
	ivl_t               prev_q, prev_d, cur_q, cur_d;
	status_t            st_q, st_d;

	logic               ov_q;
	logic [ID_W-1:0]    ogid_q, ohw_q;
	status_t            ost_q;

	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	ivl_t               ram_wdata, ram_rdata;

	logic [CW-1:0]      fid, mark_c;
	logic [CW1-1:0]     id_p1;
	logic               cur_in, hit, hl, hr;
	logic [ID_BITS-1:0] rb, re;
	logic [NW-1:0]      r_nx;
	logic [NW1-1:0]     src_dn;

	iia_ram #(
		.WIDTH($bits(ivl_t)),
		.DEPTH(MAX_INTERVALS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign fid    = CW'(req.free_id);
	assign mark_c = CW'(mark_q);
	assign id_p1  = CW1'(id_q) + CW1'(1);
	assign cur_in = r_q < cnt_q;
	assign hit    = cur_in && (CW'(cur_q.b) <= id_q);
	assign hl     = (r_q != '0) && (CW'(prev_q.e) == id_q - CW'(1));
	assign hr     = cur_in && (CW1'(cur_q.b) == id_p1);
	assign rb     = hl ? prev_q.b : ID_BITS'(id_q);
	assign re     = hr ? cur_q.e : ID_BITS'(id_q);
	assign r_nx   = r_q + NW'(1);
	assign src_dn = NW1'(i_q) + NW1'(k_q);

	assign req.ready = (state_q == S_IDLE);

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		r_d       = r_q;
		i_d       = i_q;
		k_d       = k_q;
		up_d      = up_q;
		mark_d    = mark_q;
		gid_d     = gid_q;
		id_d      = id_q;
		prev_d    = prev_q;
		cur_d     = cur_q;
		st_d      = st_q;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					gid_d   = '0;
					st_d    = ST_OK;
					state_d = S_DONE;
					if (!req.req_type) begin
						if (cnt_q == '0) begin
							if (mark_q == '1) begin
								st_d = ST_EXHAUSTED;
							end else begin
								mark_d = mark_q + ID_BITS'(1);
								gid_d  = mark_q + ID_BITS'(1);
							end
						end else begin
							ram_re  = 1'b1;
							state_d = S_ARD;
						end
					end else begin
						id_d = fid;
						r_d  = '0;
						if (fid == '0 || fid > mark_c) begin
							st_d = ST_INVALID;
						end else if (cnt_q == '0) begin
							state_d = S_DEC;
						end else begin
							ram_re  = 1'b1;
							state_d = S_SRD;
						end
					end
				end
			end
			S_ARD: begin
				gid_d = ram_rdata.b;
				if (ram_rdata.b != ram_rdata.e) begin
					ram_we      = 1'b1;
					ram_wdata.b = ram_rdata.b + ID_BITS'(1);
					ram_wdata.e = ram_rdata.e;
					state_d     = S_DONE;
				end else begin
					i_d     = '0;
					k_d     = 2'd1;
					up_d    = 1'b0;
					state_d = S_SH;
				end
			end
			S_SRD: begin
				if (CW'(ram_rdata.e) < id_q) begin
					prev_d = ram_rdata;
					r_d    = r_nx;
					if (r_nx == cnt_q) begin
						state_d = S_DEC;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = r_nx[AW-1:0];
					end
				end else begin
					cur_d   = ram_rdata;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				state_d = S_DONE;
				up_d    = 1'b0;
				if (hit) begin
					st_d = ST_FREED;
				end else if (re == mark_q) begin
					mark_d = rb - ID_BITS'(1);
					if (hl) begin
						i_d     = r_q - NW'(1);
						k_d     = hr ? 2'd2 : 2'd1;
						state_d = S_SH;
					end else if (hr) begin
						i_d     = r_q;
						k_d     = 2'd1;
						state_d = S_SH;
					end
				end else if (hl) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(r_q - NW'(1));
					ram_wdata = '{b: prev_q.b, e: re};
					if (hr) begin
						i_d     = r_q;
						k_d     = 2'd1;
						state_d = S_SH;
					end
				end else if (hr) begin
					ram_we    = 1'b1;
					ram_waddr = r_q[AW-1:0];
					ram_wdata = '{b: rb, e: cur_q.e};
				end else if (cnt_q == NW'(MAX_INTERVALS)) begin
					st_d = ST_FULL;
				end else begin
					i_d     = cnt_q;
					up_d    = 1'b1;
					state_d = S_SH;
				end
			end
			S_SH: begin
				if (up_q) begin
					if (i_q > r_q) begin
						ram_re    = 1'b1;
						ram_raddr = AW'(i_q - NW'(1));
						state_d   = S_SHW;
					end else begin
						ram_we    = 1'b1;
						ram_waddr = r_q[AW-1:0];
						ram_wdata = '{b: ID_BITS'(id_q), e: ID_BITS'(id_q)};
						cnt_d     = cnt_q + NW'(1);
						state_d   = S_DONE;
					end
				end else begin
					if (src_dn < NW1'(cnt_q)) begin
						ram_re    = 1'b1;
						ram_raddr = src_dn[AW-1:0];
						state_d   = S_SHW;
					end else begin
						cnt_d   = cnt_q - NW'(k_q);
						state_d = S_DONE;
					end
				end
			end
			S_SHW: begin
				ram_we    = 1'b1;
				ram_waddr = i_q[AW-1:0];
				ram_wdata = ram_rdata;
				i_d       = up_q ? i_q - NW'(1) : i_q + NW'(1);
				state_d   = S_SH;
			end
			S_DONE: begin
				if (!ov_q || rsp.ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			mark_q  <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			mark_q  <= mark_d;
		end
	end

	always_ff @(posedge clk) begin
		r_q    <= r_d;
		i_q    <= i_d;
		k_q    <= k_d;
		up_q   <= up_d;
		gid_q  <= gid_d;
		id_q   <= id_d;
		prev_q <= prev_d;
		cur_q  <= cur_d;
		st_q   <= st_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (state_q == S_DONE && (!ov_q || rsp.ready)) begin
			ov_q <= 1'b1;
		end else if (rsp.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!ov_q || rsp.ready)) begin
			ogid_q <= ID_W'(CW'(gid_q));
			ost_q  <= st_q;
			ohw_q  <= ID_W'(CW'(mark_q));
		end
	end

	assign rsp.valid      = ov_q;
	assign rsp.granted_id = ogid_q;
	assign rsp.status     = ost_q;
	assign rsp.high_water = ohw_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= NW'(MAX_INTERVALS))
		else $error("interval count above table size");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> state_q != S_IDLE)
		else $error("request accepted without leaving idle");

	a_full_only: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && st_q == ST_FULL) |-> cnt_q == NW'(MAX_INTERVALS))
		else $error("table full reported below capacity");

	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && st_q != ST_OK) |-> gid_q == '0)
		else $error("nonzero grant on failed request");

endmodule

`default_nettype wire
